[rtl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, quiet while reset is high.
`define B64E_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("b64e assertion failed");

// Concurrent assertion that also holds across reset.
`define B64E_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("b64e assertion failed");

`endif

[rtl/b64e_pkg.sv]
// Shared types, constants and the alphabet table of the Base64 stream encoder.
`default_nettype none
package b64e_pkg;

   localparam int unsigned QDepth = 4;
   localparam int unsigned QAw    = $clog2(QDepth);

   localparam logic [6:0] PadChar = 7'd61;

   // One classified byte: up to four characters, count minus one, end-of-message flag.
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            fin;
   } job_type;

   function automatic logic [6:0] b64_char(input logic [5:0] sextet);
      logic [6:0] code;
      begin
         if (sextet < 6'd26) begin
            code = 7'd65 + {1'b0, sextet};
         end else if (sextet < 6'd52) begin
            code = 7'd71 + {1'b0, sextet};
         end else if (sextet < 6'd62) begin
            code = {1'b0, sextet} - 7'd4;
         end else if (sextet == 6'd62) begin
            code = 7'd43;
         end else begin
            code = 7'd47;
         end
         return code;
      end
   endfunction

endpackage
`default_nettype wire

[rtl/b64e_front.sv]
// Front end: takes bytes, tracks the group phase and builds the characters each byte yields.
`default_nettype none
module b64e_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_final_byte,
   input  wire logic             q_full,
   output logic                  q_wr,
   output b64e_pkg::job_type     q_wdata
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   job_type    job;
   logic       take;

   assign full  = q_full;
   assign take  = push && !q_full;
   assign q_wr  = take;
   assign q_wdata = job;

   always_comb begin
      job.chars    = {PadChar, PadChar, PadChar, PadChar};
      job.fin      = req_final_byte;
      job.last_idx = 2'd0;
      phase_in     = phase_ff;
      carry_in     = carry_ff;
      case (phase_ff)
         2'd1: begin
            job.chars[0] = b64_char({carry_ff[1:0], req_data_byte[7:4]});
            job.chars[1] = b64_char({req_data_byte[3:0], 2'b00});
            job.last_idx = req_final_byte ? 2'd2 : 2'd0;
            carry_in     = req_data_byte[3:0];
            phase_in     = 2'd2;
         end
         2'd2: begin
            job.chars[0] = b64_char({carry_ff, req_data_byte[7:6]});
            job.chars[1] = b64_char(req_data_byte[5:0]);
            job.last_idx = 2'd1;
            carry_in     = 4'd0;
            phase_in     = 2'd0;
         end
         default: begin
            job.chars[0] = b64_char(req_data_byte[7:2]);
            job.chars[1] = b64_char({req_data_byte[1:0], 4'b0000});
            job.last_idx = req_final_byte ? 2'd3 : 2'd0;
            carry_in     = {2'b00, req_data_byte[1:0]};
            phase_in     = 2'd1;
         end
      endcase
      // end of message: start the next one clean
      if (req_final_byte) begin
         phase_in = 2'd0;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         carry_ff <= 4'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule
`default_nettype wire

[rtl/b64e_queue.sv]
// Short queue of classified bytes between the front end and the character serializer.
`default_nettype none
module b64e_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr,
   input  wire b64e_pkg::job_type wdata,
   output logic                   q_full,
   input  wire logic              rd,
   output logic                   q_empty,
   output b64e_pkg::job_type      rdata
);
   import b64e_pkg::*;

   job_type            mem_ff [QDepth];
   logic [QAw-1:0]     wptr_ff, rptr_ff;
   logic [QAw:0]       count_ff;
   logic               do_wr, do_rd;

   assign q_full  = (count_ff == (QAw+1)'(QDepth));
   assign q_empty = (count_ff == '0);
   assign rdata   = mem_ff[rptr_ff];
   assign do_wr   = wr && !q_full;
   assign do_rd   = rd && !q_empty;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (do_rd) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/b64e_back.sv]
// Back end: sends the characters of each queued byte one per cycle into the output register whenever it is free.
`default_nettype none
module b64e_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire b64e_pkg::job_type q_rdata,
   output logic                   q_rd,
   output logic                   empty,
   input  wire logic              pop,
   output logic [6:0]             rsp_out_char,
   output logic                   rsp_last_char
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, at_end;

   assign empty         = !valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   // output register frees when empty or popped this beat
   assign load   = !valid_ff || pop;
   assign at_end = (idx_ff == q_rdata.last_idx);
   assign q_rd   = load && !q_empty && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !q_empty;
         char_in  = q_rdata.chars[idx_ff];
         last_in  = q_rdata.fin && at_end;
         if (!q_empty) begin
            idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

[rtl/base64_stream_encoder_top.sv]
// Base64 stream encoder: byte queue in, ASCII character queue out.
// Bytes enter one per beat and are encoded with the standard alphabet; a byte
// marked final flushes its group, pads with '=' to a multiple of four characters
// and flags the last character. The front end takes a byte in any cycle the
// four-entry internal queue has room; the back end sends one character per cycle
// while the result is popped, so sustained throughput is set by the output side:
// each byte yields one to four characters, four per three-byte group. When the queue
// is empty, the first character of an accepted byte passes through the queue entry
// and then the output register before it shows on the result ports.
`default_nettype none
module base64_stream_encoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            empty,
   input  wire logic       pop,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_char
);
   import b64e_pkg::*;

   logic    q_full, q_wr, q_empty, q_rd;
   job_type q_wdata, q_rdata;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_wr           (q_wr),
      .q_wdata        (q_wdata)
   );

   b64e_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wdata   (q_wdata),
      .q_full  (q_full),
      .rd      (q_rd),
      .q_empty (q_empty),
      .rdata   (q_rdata)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_rdata       (q_rdata),
      .q_rd          (q_rd),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
`default_nettype wire

[rtl/b64e_checker.sv]
// Port-level checks of the Base64 stream encoder and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module b64e_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [6:0] rsp_out_char,
   input wire logic       rsp_last_char
);
   import b64e_pkg::*;

   logic [7:0] rsp_beat;
   logic       legal_char;

   assign rsp_beat   = {rsp_out_char, rsp_last_char};
   // letters, digits, '+', '/' or padding
   assign legal_char = (rsp_out_char >= 7'd65 && rsp_out_char <= 7'd90) ||
                       (rsp_out_char >= 7'd97 && rsp_out_char <= 7'd122) ||
                       (rsp_out_char >= 7'd48 && rsp_out_char <= 7'd57) ||
                       rsp_out_char == 7'd43 || rsp_out_char == 7'd47 ||
                       rsp_out_char == PadChar;

   `B64E_ASSERT(a_hold_valid, clock, reset, (!empty && !pop) |=> !empty)
   `B64E_ASSERT(a_hold_data, clock, reset, (!empty && !pop) |=> $stable(rsp_beat))
   `B64E_ASSERT(a_legal_char, clock, reset, !empty |-> legal_char)
   `B64E_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (empty && !full))

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
   .clock          (clock),
   .reset          (reset),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_out_char   (rsp_out_char),
   .rsp_last_char  (rsp_last_char)
);
`default_nettype wire
